### rtl/ljpf_pkg.sv
// shared types and constants for the lennard-jones pair force unit
package ljpf_pkg;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_PAIR  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] REG_HALF_BOX    = 2'd0;
    localparam logic [1:0] REG_CUTOFF_SQ   = 2'd1;
    localparam logic [1:0] REG_COEF_SIX    = 2'd2;
    localparam logic [1:0] REG_COEF_TWELVE = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_AXIS,
        ST_SQ,
        ST_DIV,
        ST_R2,
        ST_R6,
        ST_A,
        ST_E,
        ST_FM1,
        ST_FM2,
        ST_FX,
        ST_FY,
        ST_FZ,
        ST_RD,
        ST_WR,
        ST_READ,
        ST_OUT
    } state_t;

    // operands handed to the shared multiplier
    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

endpackage

### rtl/lj_pair_force_accumulator_unit.sv
// top level: sequencer, force memories and register port of the lj pair force unit
//
// channel  | signals                                   | handshake
// command  | start, busy, command .. pos_j_z           | taken when start && !busy
// result   | out_valid, out_index, force_*, energy     | one-cycle strobe, no stall
// config   | psel penable pwrite paddr pwdata prdata   | apb, pready tied high
//
// a pair item keeps busy high through a fold and square for each of the three axes, the
// reciprocal on the divider, nine products on the shared q32.32 multiplier and the force
// read-modify-write; a skipped pair leaves after the axis that decides it.
// a clear walks every row of the force memory. a read passes ST_READ and ST_OUT with busy
// high and then strobes its result. reset clears control state and the energy, then a
// clearing pass runs over the force memory with busy high.
module lj_pair_force_accumulator_unit #(
    parameter int MAX_PARTICLES = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         command,
    input  logic [9:0]         particle_index,
    input  logic signed [31:0] pos_i_x,
    input  logic signed [31:0] pos_i_y,
    input  logic signed [31:0] pos_i_z,
    input  logic signed [31:0] pos_j_x,
    input  logic signed [31:0] pos_j_y,
    input  logic signed [31:0] pos_j_z,
    output logic               out_valid,
    output logic [9:0]         out_index,
    output logic signed [63:0] force_x,
    output logic signed [63:0] force_y,
    output logic signed [63:0] force_z,
    output logic signed [63:0] energy,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);
    localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

    // configuration
    logic [30:0] half_box_reg;
    logic [62:0] cutoff_sq_reg;
    logic [47:0] coef_six_reg;
    logic [47:0] coef_twelve_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_box_reg    <= '0;
            cutoff_sq_reg   <= '0;
            coef_six_reg    <= '0;
            coef_twelve_reg <= '0;
        end
        else if (wr_en && paddr[2:0] == 3'd0)
        begin
            unique case (paddr[4:3])
                ljpf_pkg::REG_HALF_BOX:    half_box_reg    <= pwdata[30:0];
                ljpf_pkg::REG_CUTOFF_SQ:   cutoff_sq_reg   <= pwdata[62:0];
                ljpf_pkg::REG_COEF_SIX:    coef_six_reg    <= pwdata[47:0];
                ljpf_pkg::REG_COEF_TWELVE: coef_twelve_reg <= pwdata[47:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:3])
            ljpf_pkg::REG_HALF_BOX:    prdata = {33'd0, half_box_reg};
            ljpf_pkg::REG_CUTOFF_SQ:   prdata = {1'b0, cutoff_sq_reg};
            ljpf_pkg::REG_COEF_SIX:    prdata = {16'd0, coef_six_reg};
            ljpf_pkg::REG_COEF_TWELVE: prdata = {16'd0, coef_twelve_reg};
        endcase
    end

    // force memory: x, y, z packed in one row
    logic [191:0] mem [MAX_PARTICLES];
    logic [191:0] rd_data_reg;
    logic         mem_we;
    logic [AW-1:0] mem_wa;
    logic [191:0] mem_wd;
    logic [AW-1:0] mem_ra;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_data_reg <= mem[mem_ra];
    end

    // item and datapath registers
    ljpf_pkg::state_t state_reg, state_next;
    logic [9:0]   idx_reg;
    logic [31:0]  pi_reg [3];
    logic [31:0]  pj_reg [3];
    logic [1:0]   ax_reg;
    logic [32:0]  mag_reg [3];
    logic [2:0]   neg_reg;
    logic [63:0]  rsq_reg;
    logic [63:0]  inv_reg;
    logic [63:0]  t1_reg;
    logic [63:0]  r6_reg;
    logic [63:0]  a_reg;
    logic [63:0]  e_reg;
    logic         tneg_reg;
    logic         fneg_reg;
    logic [63:0]  fm_reg;
    logic [63:0]  fr_reg [3];
    logic         wait_reg;
    logic [AW:0]  clr_cnt_reg;
    logic signed [63:0] energy_reg;

    logic idx_ok;
    assign idx_ok = ({6'd0, idx_reg} < 16'(MAX_PARTICLES)) ||
                    (MAX_PARTICLES > 1024);

    // memory row of the item's particle
    logic [AW-1:0] idx_addr;
    assign idx_addr = AW'(idx_reg);

    // shared units
    ljpf_pkg::mul_req_t mreq;
    logic        mgo;
    logic        mdone;
    logic [63:0] mprod;
    logic        dgo;
    logic        ddone;
    logic [63:0] dquo;

    ljpf_qmul u_mul (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (mgo),
        .req  (mreq),
        .done (mdone),
        .prod (mprod)
    );

    ljpf_recip u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (dgo),
        .den  (rsq_reg),
        .done (ddone),
        .quo  (dquo)
    );

    // axis fold and square
    logic signed [33:0] d_raw;
    logic signed [33:0] d_fold;
    logic signed [33:0] hb;
    logic [33:0]  d_abs;
    logic [63:0]  sq;
    logic [64:0]  rsq_sum;
    assign hb    = {3'd0, half_box_reg};
    assign d_raw = 34'(signed'(pi_reg[ax_reg])) - 34'(signed'(pj_reg[ax_reg]));
    always_comb
    begin
        if (d_raw > hb)
            d_fold = d_raw - (hb <<< 1);
        else if (d_raw < -hb)
            d_fold = d_raw + (hb <<< 1);
        else
            d_fold = d_raw;
        d_abs = d_fold[33] ? 34'(-d_fold) : d_fold;
    end
    // squares of the stored magnitude are formed in the next cycle
    assign sq      = {31'd0, mag_reg[ax_reg]} * {31'd0, mag_reg[ax_reg]};
    assign rsq_sum = {1'b0, rsq_reg} + {1'b0, sq};

    // sign-magnitude helpers
    logic [63:0] c6q;
    logic [63:0] c12q;
    logic [63:0] c6x24;
    logic [69:0] c6x24_w;
    logic [63:0] ax48;
    logic [69:0] ax48_w;
    assign c6q     = {coef_six_reg, 16'd0};
    assign c12q    = {coef_twelve_reg, 16'd0};
    assign c6x24_w = {6'd0, c6q} * 70'd24;
    assign c6x24   = (c6x24_w[69:64] != 6'd0) ? {64{1'b1}} : c6x24_w[63:0];
    assign ax48_w  = {6'd0, a_reg} * 70'd48;
    assign ax48    = (ax48_w[69:64] != 6'd0) ? {64{1'b1}} : ax48_w[63:0];

    function automatic logic [63:0] sat_add(input logic [63:0] acc, input logic neg,
                                            input logic [63:0] m);
        logic [64:0] s;
        s = neg ? ({acc[63], acc} - {1'b0, m}) : ({acc[63], acc} + {1'b0, m});
        if (!neg && (s[64] != s[63] || (!acc[63] && s[63])))
            return SMAX;
        if (neg && (s[64] != s[63] || (acc[63] && !s[63])))
            return SMIN;
        return s[63:0];
    endfunction

    // force sums with row fields
    logic [63:0] fx_new;
    logic [63:0] fy_new;
    logic [63:0] fz_new;
    assign fx_new = sat_add(rd_data_reg[63:0], neg_reg[0] != fneg_reg, fr_reg[0]);
    assign fy_new = sat_add(rd_data_reg[127:64], neg_reg[1] != fneg_reg, fr_reg[1]);
    assign fz_new = sat_add(rd_data_reg[191:128], neg_reg[2] != fneg_reg, fr_reg[2]);

    logic accept;
    assign accept = start && !busy;
    assign busy   = (state_reg != ljpf_pkg::ST_IDLE);

    // sequencer: next state and unit controls
    always_comb
    begin
        state_next = state_reg;
        mgo        = 1'b0;
        dgo        = 1'b0;
        mreq.a     = '0;
        mreq.b     = '0;
        mem_we     = 1'b0;
        mem_wa     = clr_cnt_reg[AW-1:0];
        mem_wd     = '0;
        mem_ra     = idx_addr;
        unique case (state_reg)
            ljpf_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    priority case (command)
                        ljpf_pkg::CMD_CLEAR: state_next = ljpf_pkg::ST_CLEAR;
                        ljpf_pkg::CMD_PAIR:  state_next = ljpf_pkg::ST_AXIS;
                        ljpf_pkg::CMD_READ:  state_next = ljpf_pkg::ST_READ;
                        default:             state_next = ljpf_pkg::ST_IDLE;
                    endcase
                end
            end
            ljpf_pkg::ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (clr_cnt_reg == (AW + 1)'(MAX_PARTICLES - 1))
                    state_next = ljpf_pkg::ST_IDLE;
            end
            ljpf_pkg::ST_AXIS:
            begin
                if (!idx_ok || d_abs[33:32] != 2'd0)
                    state_next = ljpf_pkg::ST_IDLE;
                else
                    state_next = ljpf_pkg::ST_SQ;
            end
            ljpf_pkg::ST_SQ:
            begin
                if (rsq_sum[64] || rsq_sum[63:0] > {1'b0, cutoff_sq_reg})
                    state_next = ljpf_pkg::ST_IDLE;
                else if (ax_reg != 2'd2)
                    state_next = ljpf_pkg::ST_AXIS;
                else if (rsq_sum[63:0] == 64'd0)
                    state_next = ljpf_pkg::ST_IDLE;
                else
                    state_next = ljpf_pkg::ST_DIV;
            end
            ljpf_pkg::ST_DIV:
            begin
                dgo = !wait_reg;
                if (ddone)
                    state_next = ljpf_pkg::ST_R2;
            end
            ljpf_pkg::ST_R2:
            begin
                mgo    = !wait_reg;
                mreq.a = inv_reg;
                mreq.b = inv_reg;
                if (mdone)
                    state_next = ljpf_pkg::ST_R6;
            end
            ljpf_pkg::ST_R6:
            begin
                mgo    = !wait_reg;
                mreq.a = t1_reg;
                mreq.b = inv_reg;
                if (mdone)
                    state_next = ljpf_pkg::ST_A;
            end
            ljpf_pkg::ST_A:
            begin
                mgo    = !wait_reg;
                mreq.a = c12q;
                mreq.b = r6_reg;
                if (mdone)
                    state_next = ljpf_pkg::ST_E;
            end
            ljpf_pkg::ST_E:
            begin
                mgo    = !wait_reg;
                mreq.a = r6_reg;
                mreq.b = t1_reg;
                if (mdone)
                    state_next = ljpf_pkg::ST_FM1;
            end
            ljpf_pkg::ST_FM1:
            begin
                mgo    = !wait_reg;
                mreq.a = fm_reg;
                mreq.b = r6_reg;
                if (mdone)
                    state_next = ljpf_pkg::ST_FM2;
            end
            ljpf_pkg::ST_FM2:
            begin
                mgo    = !wait_reg;
                mreq.a = t1_reg;
                mreq.b = inv_reg;
                if (mdone)
                    state_next = ljpf_pkg::ST_FX;
            end
            ljpf_pkg::ST_FX:
            begin
                mgo    = !wait_reg;
                mreq.a = {15'd0, mag_reg[0], 16'd0};
                mreq.b = fm_reg;
                if (mdone)
                    state_next = ljpf_pkg::ST_FY;
            end
            ljpf_pkg::ST_FY:
            begin
                mgo    = !wait_reg;
                mreq.a = {15'd0, mag_reg[1], 16'd0};
                mreq.b = fm_reg;
                if (mdone)
                    state_next = ljpf_pkg::ST_FZ;
            end
            ljpf_pkg::ST_FZ:
            begin
                mgo    = !wait_reg;
                mreq.a = {15'd0, mag_reg[2], 16'd0};
                mreq.b = fm_reg;
                if (mdone)
                    state_next = ljpf_pkg::ST_RD;
            end
            ljpf_pkg::ST_RD:
                state_next = ljpf_pkg::ST_WR;
            ljpf_pkg::ST_WR:
            begin
                mem_we     = 1'b1;
                mem_wa     = idx_addr;
                mem_wd     = {fz_new, fy_new, fx_new};
                state_next = ljpf_pkg::ST_IDLE;
            end
            ljpf_pkg::ST_READ:
                state_next = ljpf_pkg::ST_OUT;
            ljpf_pkg::ST_OUT:
                state_next = ljpf_pkg::ST_IDLE;
            default:
                state_next = ljpf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ljpf_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            wait_reg    <= 1'b0;
            energy_reg  <= '0;
            out_valid   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid <= (state_reg == ljpf_pkg::ST_OUT);
            // one start pulse per unit step, then wait for done
            if (mgo || dgo)
                wait_reg <= 1'b1;
            else if (mdone || ddone)
                wait_reg <= 1'b0;
            if (state_reg == ljpf_pkg::ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            else
                clr_cnt_reg <= '0;
            if (accept && command == ljpf_pkg::CMD_CLEAR)
                energy_reg <= '0;
            else if (state_reg == ljpf_pkg::ST_WR)
                energy_reg <= sat_add(energy_reg, tneg_reg, e_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg   <= particle_index;
            pi_reg[0] <= pos_i_x;
            pi_reg[1] <= pos_i_y;
            pi_reg[2] <= pos_i_z;
            pj_reg[0] <= pos_j_x;
            pj_reg[1] <= pos_j_y;
            pj_reg[2] <= pos_j_z;
            ax_reg    <= 2'd0;
            rsq_reg   <= '0;
        end
        unique case (state_reg)
            ljpf_pkg::ST_AXIS:
            begin
                mag_reg[ax_reg] <= d_abs[32:0];
                neg_reg[ax_reg] <= d_fold[33];
            end
            ljpf_pkg::ST_SQ:
            begin
                rsq_reg <= rsq_sum[63:0];
                ax_reg  <= ax_reg + 2'd1;
            end
            ljpf_pkg::ST_DIV:
                if (ddone) inv_reg <= dquo;
            ljpf_pkg::ST_R2:
                if (mdone) t1_reg <= mprod;
            ljpf_pkg::ST_R6:
                if (mdone) r6_reg <= mprod;
            ljpf_pkg::ST_A:
                if (mdone)
                begin
                    a_reg    <= mprod;
                    tneg_reg <= mprod < c6q;
                    t1_reg   <= (mprod >= c6q) ? mprod - c6q : c6q - mprod;
                end
            ljpf_pkg::ST_E:
                if (mdone)
                begin
                    e_reg    <= mprod[63] ? {64{1'b1}} : {mprod[62:0], 1'b0};
                    fneg_reg <= ax48 < c6x24;
                    fm_reg   <= (ax48 >= c6x24) ? ax48 - c6x24 : c6x24 - ax48;
                end
            ljpf_pkg::ST_FM1:
                if (mdone) t1_reg <= mprod;
            ljpf_pkg::ST_FM2:
                if (mdone) fm_reg <= mprod;
            ljpf_pkg::ST_FX:
                if (mdone) fr_reg[0] <= mprod;
            ljpf_pkg::ST_FY:
                if (mdone) fr_reg[1] <= mprod;
            ljpf_pkg::ST_FZ:
                if (mdone) fr_reg[2] <= mprod;
            default:
            begin
            end
        endcase
    end

    // read result
    always_ff @(posedge clk)
    begin
        if (state_reg == ljpf_pkg::ST_OUT)
        begin
            out_index <= idx_reg;
            force_x   <= idx_ok ? rd_data_reg[63:0] : '0;
            force_y   <= idx_ok ? rd_data_reg[127:64] : '0;
            force_z   <= idx_ok ? rd_data_reg[191:128] : '0;
            energy    <= energy_reg;
        end
    end

    // results come only from a read
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(state_reg == ljpf_pkg::ST_OUT))
        else $error("result strobe without read");
    // the force memory is written only while clearing or finishing a pair
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ljpf_pkg::ST_CLEAR || state_reg == ljpf_pkg::ST_WR))
        else $error("stray force memory write");
    // the two shared units are never started together
    assert property (@(posedge clk) disable iff (!rst_n)
        !(mgo && dgo))
        else $error("multiplier and divider started together");
    // energy does not move while a read is under way
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ljpf_pkg::ST_READ) |=> $stable(energy_reg))
        else $error("energy changed during read");
endmodule

### rtl/ljpf_qmul.sv
// shared q32.32 multiplier: floor(a*b/2^32) saturating, one 32x32 partial per cycle
module ljpf_qmul (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  ljpf_pkg::mul_req_t req,
    output logic               done,
    output logic [63:0]        prod
);
    logic [1:0]   step_reg;
    logic         run_reg;
    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [129:0] acc_reg;
    logic [31:0]  pa;
    logic [31:0]  pb;
    logic [63:0]  pp;
    logic [129:0] pp_sh;

    always_comb
    begin
        pa = step_reg[1] ? a_reg[63:32] : a_reg[31:0];
        pb = step_reg[0] ? b_reg[63:32] : b_reg[31:0];
        pp = {32'd0, pa} * {32'd0, pb};
        unique case (step_reg)
            2'd0:    pp_sh = {66'd0, pp};
            2'd3:    pp_sh = {2'd0, pp, 64'd0};
            default: pp_sh = {34'd0, pp, 32'd0};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            step_reg <= 2'd0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (go)
            begin
                run_reg  <= 1'b1;
                step_reg <= 2'd0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    run_reg <= 1'b0;
                    done    <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= '0;
        end
        else if (run_reg)
            acc_reg <= acc_reg + pp_sh;
    end

    assign prod = (acc_reg[129:96] != 34'd0) ? {64{1'b1}} : acc_reg[95:32];
endmodule

### rtl/ljpf_recip.sv
// restoring divider giving floor(2^64/d) saturating, one quotient bit per cycle
module ljpf_recip (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [63:0] den,
    output logic        done,
    output logic [63:0] quo
);
    logic [6:0]  cnt_reg;
    logic        run_reg;
    logic [64:0] rem_reg;
    logic [63:0] d_reg;
    logic [64:0] q_reg;
    logic [65:0] trial;
    logic [65:0] shifted;

    always_comb
    begin
        // dividend is 1 followed by 64 zeros: feed the one at the first step
        shifted = {rem_reg, (cnt_reg == 7'd0)};
        trial   = shifted - {2'd0, d_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
            done    <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd64)
                begin
                    run_reg <= 1'b0;
                    done    <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            d_reg   <= den;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (run_reg)
        begin
            if (!trial[65])
            begin
                rem_reg <= trial[64:0];
                q_reg   <= {q_reg[63:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[64:0];
                q_reg   <= {q_reg[63:0], 1'b0};
            end
        end
    end

    assign quo = q_reg[64] ? {64{1'b1}} : q_reg[63:0];
endmodule

### bench/tb_top.sv
// self-checking testbench for the lennard-jones pair force accumulator unit
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPART     = 1024;
    localparam int STALL_MAX = 20000;
    localparam int SETTLE    = 150;
    localparam logic [63:0] ONE_Q16 = 64'd65536;
    // command code with no function
    localparam logic [1:0] CMD_SPARE = 2'd3;

    typedef struct {
        logic [9:0]         idx;
        logic signed [63:0] fx;
        logic signed [63:0] fy;
        logic signed [63:0] fz;
        logic signed [63:0] en;
    } readout_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         command;
    logic [9:0]         particle_index;
    logic signed [31:0] pos_i_x, pos_i_y, pos_i_z;
    logic signed [31:0] pos_j_x, pos_j_y, pos_j_z;
    logic               out_valid;
    logic [9:0]         out_index;
    logic signed [63:0] force_x, force_y, force_z, energy;
    logic               psel, penable, pwrite;
    logic [4:0]         paddr;
    logic [63:0]        pwdata;
    logic [63:0]        prdata;
    logic               pready;

    lj_pair_force_accumulator_unit uut (.*);

    // predictor state
    logic [30:0]        half_box_q;
    logic [62:0]        cutoff_sq_q;
    logic [47:0]        coef_six_q;
    logic [47:0]        coef_twelve_q;
    logic signed [63:0] fx_mem [NPART];
    logic signed [63:0] fy_mem [NPART];
    logic signed [63:0] fz_mem [NPART];
    logic signed [63:0] energy_acc;

    readout_t pending_reads[$];
    int       errors;
    int       idle_cycles;
    bit       gaps_on;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return (|p[127:96]) ? '1 : p[95:32];
    endfunction

    function automatic logic [63:0] kmul(input logic [63:0] a, input logic [7:0] k);
        logic [71:0] p;
        p = {8'd0, a} * {64'd0, k};
        return (|p[71:64]) ? '1 : p[63:0];
    endfunction

    function automatic logic [63:0] mag_diff(input logic [63:0] a, input logic [63:0] b,
                                             output bit neg);
        neg = a < b;
        return neg ? b - a : a - b;
    endfunction

    function automatic logic signed [63:0] acc_sat(input logic signed [63:0] a, input bit neg,
                                                   input logic [63:0] m);
        logic signed [65:0] s;
        s = neg ? $signed({{2{a[63]}}, a}) - $signed({2'b00, m})
                : $signed({{2{a[63]}}, a}) + $signed({2'b00, m});
        if (s > 66'sh0_7FFF_FFFF_FFFF_FFFF)
            return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (s < -66'sh0_8000_0000_0000_0000)
            return 64'sh8000_0000_0000_0000;
        return s[63:0];
    endfunction

    task automatic accumulate_pair(input logic [9:0] idx, input logic signed [31:0] pi[3],
                                   input logic signed [31:0] pj[3]);
        logic signed [33:0] d, h;
        logic [63:0] mag[3];
        bit          dneg[3];
        logic [64:0] rsq, quot;
        logic [63:0] inv, r6, c6, c12, a, t, e, fm;
        bit          tneg, fneg;
        rsq = '0;
        h = $signed({3'b000, half_box_q});
        for (int k = 0; k < 3; k++)
        begin
            d = $signed({{2{pi[k][31]}}, pi[k]}) - $signed({{2{pj[k][31]}}, pj[k]});
            if (d > h)
                d = d - (h <<< 1);
            else if (d < -h)
                d = d + (h <<< 1);
            dneg[k] = d < 0;
            mag[k] = dneg[k] ? 64'(-d) : 64'(d);
            if (mag[k] >= 64'h1_0000_0000)
                return;
            rsq = rsq + {1'b0, mag[k] * mag[k]};
            if (rsq[64] || rsq > {2'b00, cutoff_sq_q})
                return;
        end
        if (rsq == 0)
            return;
        quot = (65'd1 << 64) / rsq;
        inv = quot[64] ? '1 : quot[63:0];
        r6 = qmul(qmul(inv, inv), inv);
        c6 = {coef_six_q, 16'd0};
        c12 = {coef_twelve_q, 16'd0};
        a = qmul(c12, r6);
        t = mag_diff(a, c6, tneg);
        e = kmul(qmul(r6, t), 8'd2);
        energy_acc = acc_sat(energy_acc, tneg, e);
        fm = mag_diff(kmul(a, 8'd48), kmul(c6, 8'd24), fneg);
        fm = qmul(qmul(fm, r6), inv);
        fx_mem[idx] = acc_sat(fx_mem[idx], dneg[0] != fneg, qmul(mag[0] << 16, fm));
        fy_mem[idx] = acc_sat(fy_mem[idx], dneg[1] != fneg, qmul(mag[1] << 16, fm));
        fz_mem[idx] = acc_sat(fz_mem[idx], dneg[2] != fneg, qmul(mag[2] << 16, fm));
    endtask

    task automatic clear_store();
        for (int n = 0; n < NPART; n++)
        begin
            fx_mem[n] = '0;
            fy_mem[n] = '0;
            fz_mem[n] = '0;
        end
        energy_acc = '0;
    endtask

    // sends one item, waits for it to be taken and updates the predictor
    task automatic send_item(input logic [1:0] cmd, input logic [9:0] idx,
                             input logic signed [31:0] pi[3], input logic signed [31:0] pj[3]);
        readout_t r;
        @(negedge clk);
        if (gaps_on && $urandom_range(3) == 0)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        command = cmd;
        particle_index = idx;
        pos_i_x = pi[0];
        pos_i_y = pi[1];
        pos_i_z = pi[2];
        pos_j_x = pj[0];
        pos_j_y = pj[1];
        pos_j_z = pj[2];
        start = 1'b1;
        do
            @(posedge clk);
        while (busy);
        case (cmd)
            ljpf_pkg::CMD_CLEAR: clear_store();
            ljpf_pkg::CMD_PAIR:  accumulate_pair(idx, pi, pj);
            ljpf_pkg::CMD_READ:
            begin
                r.idx = idx;
                r.fx = fx_mem[idx];
                r.fy = fy_mem[idx];
                r.fz = fz_mem[idx];
                r.en = energy_acc;
                pending_reads = {pending_reads, r};
            end
            default: ;
        endcase
    endtask

    task automatic send_simple(input logic [1:0] cmd, input logic [9:0] idx);
        logic signed [31:0] z[3];
        z = '{default: 0};
        send_item(cmd, idx, z, z);
    endtask

    task automatic settle();
        @(negedge clk);
        start = 1'b0;
        do
            @(posedge clk);
        while (busy || pending_reads.size() != 0);
        repeat (SETTLE) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic reg_write(input logic [1:0] which, input logic [63:0] value);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {which, 3'b000};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (which)
            ljpf_pkg::REG_HALF_BOX:    half_box_q = value[30:0];
            ljpf_pkg::REG_CUTOFF_SQ:   cutoff_sq_q = value[62:0];
            ljpf_pkg::REG_COEF_SIX:    coef_six_q = value[47:0];
            ljpf_pkg::REG_COEF_TWELVE: coef_twelve_q = value[47:0];
            default: ;
        endcase
    endtask

    task automatic set_params(input logic [63:0] hb, input logic [63:0] cut,
                              input logic [63:0] c6, input logic [63:0] c12);
        settle();
        reg_write(ljpf_pkg::REG_HALF_BOX, hb);
        reg_write(ljpf_pkg::REG_CUTOFF_SQ, cut);
        reg_write(ljpf_pkg::REG_COEF_SIX, c6);
        reg_write(ljpf_pkg::REG_COEF_TWELVE, c12);
    endtask

    task automatic test_after_reset();
        send_simple(ljpf_pkg::CMD_READ, 10'd0);
        send_simple(ljpf_pkg::CMD_READ, 10'd1023);
    endtask

    task automatic test_directed();
        logic signed [31:0] pi[3], pj[3];
        set_params(64'd655360, 64'h6_4000_0000, ONE_Q16, ONE_Q16);
        // zero distance
        pi = '{32'sd1000, -32'sd5, 32'sd7};
        send_item(ljpf_pkg::CMD_PAIR, 10'd0, pi, pi);
        // smallest distance, one raw unit
        pj = '{32'sd999, -32'sd5, 32'sd7};
        send_item(ljpf_pkg::CMD_PAIR, 10'd0, pi, pj);
        send_simple(ljpf_pkg::CMD_READ, 10'd0);
        // ordinary pair at about 1.1 apart, top index
        pi = '{32'sd72090, 32'sd0, 32'sd0};
        pj = '{32'sd0, 32'sd0, 32'sd0};
        send_item(ljpf_pkg::CMD_PAIR, 10'd1023, pi, pj);
        send_item(ljpf_pkg::CMD_PAIR, 10'd1023, pj, pi);
        pi = '{32'sd0, -32'sd40000, 32'sd30000};
        send_item(ljpf_pkg::CMD_PAIR, 10'd1023, pi, pj);
        send_simple(ljpf_pkg::CMD_READ, 10'd1023);
        // minimum image folding both ways
        pi = '{32'sd0, 32'sd0, 32'sd0};
        pj = '{32'sd1245184, 32'sd0, 32'sd0};
        send_item(ljpf_pkg::CMD_PAIR, 10'd5, pi, pj);
        send_item(ljpf_pkg::CMD_PAIR, 10'd5, pj, pi);
        send_simple(ljpf_pkg::CMD_READ, 10'd5);
        // beyond cutoff
        pj = '{32'sd0, 32'sd0, 32'sd200000};
        send_item(ljpf_pkg::CMD_PAIR, 10'd5, pi, pj);
        send_simple(ljpf_pkg::CMD_READ, 10'd5);
        // unused command and clear
        send_simple(CMD_SPARE, 10'd5);
        send_simple(ljpf_pkg::CMD_CLEAR, 10'd0);
        send_simple(ljpf_pkg::CMD_READ, 10'd1023);
    endtask

    task automatic test_extremes();
        logic signed [31:0] pi[3], pj[3];
        // distance overflow: partial sum of squares passes 64 bits
        set_params(64'd0, 64'hFFFF_FFFF_FFFF_FFFF, '1, '1);
        pi = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
        pj = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
        send_item(ljpf_pkg::CMD_PAIR, 10'd3, pi, pj);
        pj = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
        send_item(ljpf_pkg::CMD_PAIR, 10'd3, pi, pj);
        pj = '{32'sh7FFF_FFF0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFE};
        send_item(ljpf_pkg::CMD_PAIR, 10'd3, pi, pj);
        send_item(ljpf_pkg::CMD_PAIR, 10'd3, pi, pj);
        send_simple(ljpf_pkg::CMD_READ, 10'd3);
        set_params(64'h7FFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0, 64'd0);
        pj = '{32'sh8000_0000, 32'sh0, 32'sh1234};
        send_item(ljpf_pkg::CMD_PAIR, 10'd3, pi, pj);
        send_simple(ljpf_pkg::CMD_READ, 10'd3);
    endtask

    task automatic random_pairs(input int count, input int span);
        logic signed [31:0] pi[3], pj[3];
        logic [9:0]  idx;
        int          pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            idx = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(7));
            for (int k = 0; k < 3; k++)
            begin
                pi[k] = $urandom;
                pj[k] = pi[k] + $signed($urandom_range(2 * span)) - span;
                if ($urandom_range(3) == 0)
                    pj[k] = pj[k] + 32'(($urandom_range(1) ? 1 : -1) *
                                        $signed({1'b0, half_box_q, 1'b0}));
            end
            if (pick < 8)
            begin
                for (int k = 0; k < 3; k++)
                    pj[k] = $urandom;
                send_item(ljpf_pkg::CMD_PAIR, 10'($urandom), pi, pj);
            end
            else if (pick < 11)
                send_simple(ljpf_pkg::CMD_CLEAR, idx);
            else if (pick < 12)
                send_item(CMD_SPARE, idx, pi, pj);
            else if (pick < 32)
                send_simple(ljpf_pkg::CMD_READ, ($urandom_range(4) == 0) ? 10'($urandom) : idx);
            else
                send_item(ljpf_pkg::CMD_PAIR, idx, pi, pj);
        end
    endtask

    task automatic test_random();
        set_params(64'd655360, 64'h6_4000_0000, ONE_Q16, ONE_Q16);
        random_pairs(120, 3 * 65536);
        set_params(64'd131072, 64'h1_0000_0000, 64'd3 << 16, 64'd2 << 16);
        random_pairs(100, 2 * 65536);
        set_params({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom});
        random_pairs(80, 65536);
        set_params(64'h7FFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF);
        random_pairs(80, 4000);
        set_params(64'd0, 64'd0, 64'd0, 64'd0);
        random_pairs(40, 4);
        set_params(64'd400000, 64'h9_0000_0000, 64'd50000, 64'd90000);
        random_pairs(80, 2 * 65536);
        // closing stretch with no gaps
        gaps_on = 1'b0;
        random_pairs(80, 2 * 65536);
    endtask

    always @(posedge clk)
    begin
        readout_t w;
        if (rst_n && out_valid)
        begin
            if (pending_reads.size() == 0)
            begin
                $display("unexpected result for index %0d at %0t", out_index, $realtime);
                errors++;
            end
            else
            begin
                w = pending_reads.pop_front();
                if (out_index !== w.idx) report("out_index", 64'(out_index), 64'(w.idx));
                if (force_x !== w.fx) report("force_x", force_x, w.fx);
                if (force_y !== w.fy) report("force_y", force_y, w.fy);
                if (force_z !== w.fz) report("force_z", force_z, w.fz);
                if (energy !== w.en) report("energy", energy, w.en);
            end
        end
    end

    // stall watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || out_valid || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_MAX)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        idle_cycles = 0;
        gaps_on = 1'b1;
        rst_n = 1'b0;
        start = 1'b0;
        command = ljpf_pkg::CMD_CLEAR;
        particle_index = '0;
        pos_i_x = '0;
        pos_i_y = '0;
        pos_i_z = '0;
        pos_j_x = '0;
        pos_j_y = '0;
        pos_j_z = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        half_box_q = '0;
        cutoff_sq_q = '0;
        coef_six_q = '0;
        coef_twelve_q = '0;
        clear_store();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_after_reset();
        test_directed();
        test_extremes();
        test_random();

        @(negedge clk);
        start = 1'b0;
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

### sim.f
rtl/ljpf_pkg.sv
rtl/ljpf_qmul.sv
rtl/ljpf_recip.sv
rtl/lj_pair_force_accumulator_unit.sv
bench/tb_top.sv
